// ----- rtl/finder_pattern_row_scanner_assert.svh -----
// Assertion macros for the finder pattern row scanner checker.
`ifndef FINDER_PATTERN_ROW_SCANNER_ASSERT_SVH
`define FINDER_PATTERN_ROW_SCANNER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FPRS_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("fprs assertion failed: same-cycle check");

// Next-cycle implication, sampled on clk, off during reset.
`define FPRS_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("fprs assertion failed: next-cycle check");

`endif

// ----- rtl/fprs_pkg.sv -----
// Shared types and constants for the finder pattern row scanner.
package fprs_pkg;

    localparam int CNT_W             = 11;
    localparam int OUT_W             = 11;
    localparam int PIX_W             = 8;
    localparam int TOL_W             = 6;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 8;
    localparam int PROD_W            = 20;
    localparam int NUM_BANDS         = 7;
    localparam int MAX_ROW_WIDTH_DEF = 2048;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [PIX_W-1:0] WHITE_THRESHOLD_RST = 8'd100;
    localparam logic [TOL_W-1:0] HIGH_TOLERANCE_RST  = 6'd20;
    localparam logic [TOL_W-1:0] LOW_TOLERANCE_RST   = 6'd12;

    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TOLERANCE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_TOLERANCE   = 2'd2;

    typedef enum logic [6:0] {
        ST_OUT = 7'b0000001,
        ST_B1  = 7'b0000010,
        ST_W2  = 7'b0000100,
        ST_B3  = 7'b0001000,
        ST_W4  = 7'b0010000,
        ST_B5  = 7'b0100000,
        ST_W6  = 7'b1000000
    } band_state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // Count scaled by sixteen, in product width.
    function automatic logic [PROD_W-1:0] x16(input logic [CNT_W-1:0] v);
        return PROD_W'(v) << 4;
    endfunction

    function automatic logic [PROD_W-1:0] mul_tol(input logic [CNT_W-1:0] c,
                                                  input logic [TOL_W-1:0] t);
        return PROD_W'(c) * PROD_W'(t);
    endfunction

endpackage

// ----- rtl/finder_pattern_row_scanner.sv -----
// Finder pattern row scanner: thresholds pixels and detects 1:1:3:1:1 band runs per row.
// A closing pixel is staged in the input register; its result loads the output register.
// Throughput: one pixel per cycle; the input register feeds the band logic, whose result
// lands in an output register, so a stall occurs only while a result waits unread.
// Reset: band state, band counts and column counter clear; thresholds return to 100/20/12.
// A row-start pixel clears band state, counts and column before it is processed.
module finder_pattern_row_scanner
    import fprs_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIX_W-1:0]      grey_level,
    input  logic                  row_start,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_W-1:0]      center_column,
    output logic [OUT_W-1:0]      center_width,
    output logic [OUT_W-1:0]      unit_width
);

    localparam int COL_W  = $clog2(MAX_ROW_WIDTH);
    localparam int DIFF_W = ((COL_W > CNT_W + 2) ? COL_W : CNT_W + 2) + 1;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_ROW_WIDTH - 1);

    // configuration
    logic [PIX_W-1:0] white_threshold_reg;
    logic [TOL_W-1:0] high_tolerance_reg;
    logic [TOL_W-1:0] low_tolerance_reg;

    // input register
    logic             stg_valid_reg;
    logic [PIX_W-1:0] stg_grey_reg;
    logic             stg_row_start_reg;

    // scan state
    band_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg  [NUM_BANDS];
    logic [CNT_W-1:0] cnt_next [NUM_BANDS];
    logic [COL_W-1:0] col_reg, col_next;

    // result register
    logic             out_valid_reg;
    logic [OUT_W-1:0] center_column_reg, center_column_next;
    logic [OUT_W-1:0] center_width_reg;
    logic [OUT_W-1:0] unit_width_reg;

    logic             advance;
    logic             in_xfer;
    logic             found;
    band_state_t      st;
    logic [CNT_W-1:0] c [NUM_BANDS];
    logic [COL_W-1:0] x;
    logic             white;
    logic [CNT_W-1:0] n_inc;
    logic [PROD_W-1:0] m0h, m1h, m1l, m2h, m1h3, m1l3;
    logic [DIFF_W-1:0] col_sum, col_diff;

    assign cfg_ready = 1'b1;
    assign advance   = stg_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !stg_valid_reg || advance;
    assign in_xfer   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            white_threshold_reg <= WHITE_THRESHOLD_RST;
            high_tolerance_reg  <= HIGH_TOLERANCE_RST;
            low_tolerance_reg   <= LOW_TOLERANCE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_WHITE_THRESHOLD: white_threshold_reg <= cfg_data;
                CFG_HIGH_TOLERANCE:  high_tolerance_reg  <= cfg_data[TOL_W-1:0];
                CFG_LOW_TOLERANCE:   low_tolerance_reg   <= cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            stg_valid_reg <= 1'b0;
        end else begin
            stg_valid_reg <= in_xfer || (stg_valid_reg && !advance);
        end
    end

    always_ff @(posedge clk) begin
        if (in_xfer) begin
            stg_grey_reg      <= grey_level;
            stg_row_start_reg <= row_start;
        end
    end

    // row start clears the view of state before the pixel is processed
    always_comb begin
        st = stg_row_start_reg ? ST_OUT : state_reg;
        x  = stg_row_start_reg ? '0 : col_reg;
        for (int i = 0; i < NUM_BANDS; i++) begin
            c[i] = stg_row_start_reg ? '0 : cnt_reg[i];
        end
        white = stg_grey_reg > white_threshold_reg;
        m0h   = mul_tol(c[0], high_tolerance_reg);
        m1h   = mul_tol(c[1], high_tolerance_reg);
        m1l   = mul_tol(c[1], low_tolerance_reg);
        m2h   = mul_tol(c[2], high_tolerance_reg);
        m1h3  = (m1h << 1) + m1h;
        m1l3  = (m1l << 1) + m1l;
    end

    always_comb begin
        state_next = st;
        for (int i = 0; i < NUM_BANDS; i++) begin
            cnt_next[i] = c[i];
        end
        found = 1'b0;
        n_inc = '0;
        unique case (st)
            ST_B1: begin
                if (!white) begin
                    n_inc       = sat_inc(c[1]);
                    cnt_next[1] = n_inc;
                    if (x16(n_inc) > m0h + PROD_W'(16)) begin
                        state_next  = ST_OUT;
                        cnt_next[0] = '0;
                    end
                end else begin
                    state_next  = ST_W2;
                    cnt_next[2] = CNT_W'(1);
                end
            end
            ST_W2: begin
                if (white) begin
                    n_inc       = sat_inc(c[2]);
                    cnt_next[2] = n_inc;
                    if (m1h + PROD_W'(16) < x16(n_inc)) begin
                        state_next  = ST_OUT;
                        cnt_next[0] = n_inc;
                    end
                end else if (m1l < x16(c[2]) + PROD_W'(16)) begin
                    state_next  = ST_B3;
                    cnt_next[3] = CNT_W'(1);
                end else begin
                    state_next  = ST_OUT;
                    cnt_next[0] = c[2];
                end
            end
            ST_B3: begin
                if (!white) begin
                    n_inc       = sat_inc(c[3]);
                    cnt_next[3] = n_inc;
                    if (m1h3 + PROD_W'(48) < x16(n_inc)) begin
                        state_next  = ST_OUT;
                        cnt_next[0] = '0;
                    end
                end else if (m1l3 < x16(c[3]) + PROD_W'(48)) begin
                    state_next  = ST_W4;
                    cnt_next[4] = CNT_W'(1);
                end else if (m2h + PROD_W'(16) > x16(c[3])) begin
                    // slide the window: old middle white becomes the leading white
                    state_next  = ST_W2;
                    cnt_next[0] = c[2];
                    cnt_next[1] = c[3];
                    cnt_next[2] = CNT_W'(1);
                end else begin
                    state_next  = ST_OUT;
                    cnt_next[0] = '0;
                end
            end
            ST_W4: begin
                if (white) begin
                    n_inc       = sat_inc(c[4]);
                    cnt_next[4] = n_inc;
                    if (x16(n_inc) > m1h + PROD_W'(16)) begin
                        state_next  = ST_OUT;
                        cnt_next[0] = n_inc;
                    end
                end else if (m1l < x16(c[4]) + PROD_W'(16)) begin
                    state_next  = ST_B5;
                    cnt_next[5] = CNT_W'(1);
                end else begin
                    state_next  = ST_OUT;
                    cnt_next[0] = c[4];
                end
            end
            ST_B5: begin
                if (!white) begin
                    n_inc       = sat_inc(c[5]);
                    cnt_next[5] = n_inc;
                    if (x16(n_inc) > m1h + PROD_W'(16)) begin
                        state_next  = ST_OUT;
                        cnt_next[0] = '0;
                    end
                end else if (m1l < x16(c[5]) + PROD_W'(16)) begin
                    state_next  = ST_W6;
                    cnt_next[6] = CNT_W'(1);
                end else begin
                    state_next  = ST_OUT;
                    cnt_next[0] = '0;
                end
            end
            ST_W6: begin
                if (white) begin
                    n_inc       = sat_inc(c[6]);
                    cnt_next[6] = n_inc;
                    if (x16(n_inc) + PROD_W'(16) > m1l) begin
                        state_next  = ST_OUT;
                        cnt_next[0] = n_inc;
                        found       = 1'b1;
                    end
                end else begin
                    state_next  = ST_OUT;
                    cnt_next[0] = c[6];
                end
            end
            default: begin
                // outside white, and any unused code
                state_next = ST_OUT;
                if (white) begin
                    n_inc       = sat_inc(c[0]);
                    cnt_next[0] = n_inc;
                end else if (c[0] != '0) begin
                    state_next  = ST_B1;
                    cnt_next[1] = CNT_W'(1);
                end
            end
        endcase
    end

    // center = column - c6 (counting this pixel) - c5 - c4 - c3/2, clamped at zero
    always_comb begin
        col_sum  = DIFF_W'(cnt_next[6]) + DIFF_W'(c[5]) + DIFF_W'(c[4])
                 + DIFF_W'(c[3] >> 1);
        col_diff = DIFF_W'(x) - col_sum;
        center_column_next = col_diff[DIFF_W-1] ? '0 : col_diff[OUT_W-1:0];
        col_next = (x != COL_LAST) ? x + 1'b1 : x;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_OUT;
            col_reg   <= '0;
            for (int i = 0; i < NUM_BANDS; i++) begin
                cnt_reg[i] <= '0;
            end
        end else if (advance) begin
            state_reg <= state_next;
            col_reg   <= col_next;
            for (int i = 0; i < NUM_BANDS; i++) begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance && found) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (advance && found) begin
            center_column_reg <= center_column_next;
            center_width_reg  <= c[3];
            unit_width_reg    <= c[1];
        end
    end

    assign out_valid     = out_valid_reg;
    assign center_column = center_column_reg;
    assign center_width  = center_width_reg;
    assign unit_width    = unit_width_reg;

endmodule

// ----- rtl/fprs_checker.sv -----
// Port-level checker for the finder pattern row scanner, with its bind.
`include "finder_pattern_row_scanner_assert.svh"

module fprs_checker
    import fprs_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [OUT_W-1:0]      center_width,
    input logic [OUT_W-1:0]      unit_width
);

    // hold a result until its transfer
    `FPRS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    `FPRS_ASSERT_NOW(a_cfg_always_ready, cfg_valid, cfg_ready)

    // with the output register empty the input side never stalls
    `FPRS_ASSERT_NOW(a_in_ready_when_out_empty, !out_valid, in_ready)

    // a pattern always has nonempty first and centre black bands
    `FPRS_ASSERT_NOW(a_bands_nonzero, out_valid, (center_width != '0) && (unit_width != '0))

endmodule

bind finder_pattern_row_scanner fprs_checker u_fprs_checker (.*);
